// ===== hdl/dqp_pkg.sv =====
// Shared types, constants and the label character check for the DNS question parser.
// Has no dependencies; each other file but dqp_checker refers to it by scoped names.
package dqp_pkg;

	localparam int unsigned POSITION_BITS_DEF = 16;
	localparam int unsigned OUT_BITS = 16;
	localparam logic [7:0] LABEL_LIMIT_RESET = 8'd63;
	localparam logic [OUT_BITS-1:0] QUESTION_TAIL = 16'd4;

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DIGIT_LO = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI = 8'h39;
	localparam logic [7:0] CH_UPPER_LO = 8'h41;
	localparam logic [7:0] CH_UPPER_HI = 8'h5A;
	localparam logic [7:0] CH_LOWER_LO = 8'h61;
	localparam logic [7:0] CH_LOWER_HI = 8'h7A;

	typedef enum logic [6:0] {
		PH_LEN      = 7'b0000001,
		PH_LABEL    = 7'b0000010,
		PH_TYPE_HI  = 7'b0000100,
		PH_TYPE_LO  = 7'b0001000,
		PH_CLASS_HI = 7'b0010000,
		PH_CLASS_LO = 7'b0100000,
		PH_SKIP     = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic                parse_error;
		logic [OUT_BITS-1:0] name_length;
		logic [OUT_BITS-1:0] query_type;
		logic [OUT_BITS-1:0] query_class;
		logic [OUT_BITS-1:0] consumed_length;
	} result_t;

	function automatic logic char_ok(input logic [7:0] c);
		char_ok = c inside {CH_STAR, CH_HYPHEN, CH_UNDERSCORE,
			[CH_DIGIT_LO:CH_DIGIT_HI], [CH_UPPER_LO:CH_UPPER_HI],
			[CH_LOWER_LO:CH_LOWER_HI]};
	endfunction

endpackage

// ===== hdl/dqp_in_stage.sv =====
// Input register of the DNS question parser: holds one byte transaction until the parser takes it.
// Depends on dqp_pkg for the item type.
module dqp_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  dqp_pkg::item_t in_item,
	input  logic          advance,
	output logic          valid_s1,
	output dqp_pkg::item_t item_s1
);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hdl/dqp_parse_core.sv =====
// Parse state machine of the DNS question parser: label checks, name length count and type/class capture.
// Depends on dqp_pkg for the phase encoding, item and result types and the character check.
module dqp_parse_core #(
	parameter int unsigned POSITION_BITS = dqp_pkg::POSITION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [7:0]       cfg_data,
	input  logic             fire,
	input  dqp_pkg::item_t   item_s1,
	output logic             res_valid,
	output dqp_pkg::result_t res
);

	localparam longint unsigned PosMax = (64'd1 << POSITION_BITS) - 64'd1;
	localparam longint unsigned CapFull = (PosMax < 64'd65531) ? PosMax : 64'd65531;
	localparam logic [POSITION_BITS-1:0] NameCap = POSITION_BITS'(CapFull);

	dqp_pkg::phase_t            phase_q, phase_d;
	logic [7:0]                 rem_q, rem_d, rem_dec;
	logic [POSITION_BITS-1:0]   pos_q, pos_d, pos_inc;
	logic [15:0]                type_q, type_d;
	logic [7:0]                 class_hi_q, class_hi_d;
	logic [7:0]                 limit_q;
	logic                       err;
	logic                       rearm;
	logic                       at_cap;
	logic [7:0]                 b;
	logic                       last;
	logic [15:0]                name_len;

	assign b = item_s1.data_byte;
	assign last = item_s1.last_byte;
	assign at_cap = pos_q >= NameCap;
	assign pos_inc = pos_q + POSITION_BITS'(1);
	assign rem_dec = rem_q - 8'd1;
	assign name_len = 32'(pos_q) >> 0 == 0 ? 16'd0 : 16'(32'(pos_q));

	always_comb begin
		phase_d = phase_q;
		rem_d = rem_q;
		pos_d = pos_q;
		type_d = type_q;
		class_hi_d = class_hi_q;
		err = 1'b0;
		rearm = 1'b0;
		res_valid = 1'b0;
		res = '0;
		case (phase_q)
			dqp_pkg::PH_LEN: begin
				if (at_cap) begin
					err = 1'b1;
				end else begin
					pos_d = pos_inc;
					if (b == 8'd0) begin
						if (last) begin
							err = 1'b1;
						end else begin
							phase_d = dqp_pkg::PH_TYPE_HI;
						end
					end else if (b > limit_q || last) begin
						err = 1'b1;
					end else begin
						rem_d = b;
						phase_d = dqp_pkg::PH_LABEL;
					end
				end
			end
			dqp_pkg::PH_LABEL: begin
				if (at_cap || !dqp_pkg::char_ok(b) || last) begin
					err = 1'b1;
				end else begin
					pos_d = pos_inc;
					rem_d = rem_dec;
					if (rem_dec == 8'd0) begin
						phase_d = dqp_pkg::PH_LEN;
					end
				end
			end
			dqp_pkg::PH_TYPE_HI: begin
				if (last) begin
					err = 1'b1;
				end else begin
					type_d = {b, 8'd0};
					phase_d = dqp_pkg::PH_TYPE_LO;
				end
			end
			dqp_pkg::PH_TYPE_LO: begin
				if (last) begin
					err = 1'b1;
				end else begin
					type_d = {type_q[15:8], type_q[7:0] | b};
					phase_d = dqp_pkg::PH_CLASS_HI;
				end
			end
			dqp_pkg::PH_CLASS_HI: begin
				if (last) begin
					err = 1'b1;
				end else begin
					class_hi_d = b;
					phase_d = dqp_pkg::PH_CLASS_LO;
				end
			end
			dqp_pkg::PH_CLASS_LO: begin
				res_valid = 1'b1;
				res.parse_error = 1'b0;
				res.name_length = name_len;
				res.query_type = type_q;
				res.query_class = {class_hi_q, b};
				res.consumed_length = name_len + dqp_pkg::QUESTION_TAIL;
				if (last) begin
					rearm = 1'b1;
				end else begin
					phase_d = dqp_pkg::PH_SKIP;
				end
			end
			dqp_pkg::PH_SKIP: begin
				rearm = last;
			end
			default: begin
				rearm = 1'b1;
			end
		endcase
		if (err) begin
			res_valid = 1'b1;
			res = '0;
			res.parse_error = 1'b1;
			if (last) begin
				rearm = 1'b1;
			end else begin
				phase_d = dqp_pkg::PH_SKIP;
			end
		end
		if (rearm) begin
			phase_d = dqp_pkg::PH_LEN;
			rem_d = 8'd0;
			pos_d = '0;
			type_d = 16'd0;
			class_hi_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dqp_pkg::PH_LEN;
			rem_q <= 8'd0;
			pos_q <= '0;
			type_q <= 16'd0;
			class_hi_q <= 8'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			rem_q <= rem_d;
			pos_q <= pos_d;
			type_q <= type_d;
			class_hi_q <= class_hi_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= dqp_pkg::LABEL_LIMIT_RESET;
		end else if (cfg_write) begin
			limit_q <= cfg_data;
		end
	end

endmodule

// ===== hdl/dqp_out_stage.sv =====
// Result register of the DNS question parser: holds one result transaction until the consumer takes it.
// Depends on dqp_pkg for the result type.
module dqp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             res_valid,
	input  dqp_pkg::result_t res,
	input  logic             out_stall,
	output logic             advance,
	output logic             out_valid,
	output dqp_pkg::result_t res_q
);

	assign advance = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ===== hdl/dns_question_parser_unit.sv =====
// Top level of the DNS question parser: input register, parse state machine and result register.
// Depends on dqp_pkg, dqp_in_stage, dqp_parse_core and dqp_out_stage.
//
// The parser takes one byte of a DNS question section per cycle while in_stall is low and gives at
// most one result per buffer, either the name length, query type, query class and consumed length,
// or an error flag. A byte is taken in every cycle in which the result register is empty or being
// emptied; the input register and then the result register lie between a byte and its result.
// in_stall rises only when a result waits in the output register under out_stall while a byte
// already sits in the input register. The label limit register is written through the cfg port,
// which is always ready; write it only while no buffer is in progress.
module dns_question_parser_unit #(
	parameter int unsigned POSITION_BITS = dqp_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        parse_error,
	output logic [15:0] name_length,
	output logic [15:0] query_type,
	output logic [15:0] query_class,
	output logic [15:0] consumed_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	dqp_pkg::item_t   in_item;
	dqp_pkg::item_t   item_s1;
	dqp_pkg::result_t res;
	dqp_pkg::result_t res_q;
	logic             valid_s1;
	logic             advance;
	logic             fire;
	logic             res_valid;

	assign cfg_ready = 1'b1;
	assign in_item.data_byte = data_byte;
	assign in_item.last_byte = last_byte;
	assign fire = valid_s1 && advance;

	dqp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dqp_parse_core #(
		.POSITION_BITS (POSITION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	dqp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign parse_error = res_q.parse_error;
	assign name_length = res_q.name_length;
	assign query_type = res_q.query_type;
	assign query_class = res_q.query_class;
	assign consumed_length = res_q.consumed_length;

endmodule

// ===== hdl/dqp_checker.sv =====
// Port-level checks for the DNS question parser, attached to the top level by a bind statement.
// Depends on dns_question_parser_unit only through its ports.
module dqp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        parse_error,
	input logic [15:0] name_length,
	input logic [15:0] query_type,
	input logic [15:0] query_class,
	input logic [15:0] consumed_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result transaction dropped while stalled.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("Input stalled without a blocked result.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_error |-> name_length == 16'd0 && query_type == 16'd0
			&& query_class == 16'd0 && consumed_length == 16'd0)
		else $error("Error result carries nonzero fields.");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parse_error |-> consumed_length == name_length + 16'd4
			&& name_length != 16'd0)
		else $error("Success result lengths are inconsistent.");

endmodule

bind dns_question_parser_unit dqp_checker u_dqp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.parse_error     (parse_error),
	.name_length     (name_length),
	.query_type      (query_type),
	.query_class     (query_class),
	.consumed_length (consumed_length)
);
